FILE: src/msm_pkg.sv
package msm_pkg;

  // Filter geometry.
  localparam int WINDOW      = 10;
  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 12;

  // Fixed widths of the beat fields.
  localparam int CHAN_FIELD_W   = 2;
  localparam int SAMPLE_FIELD_W = 12;
  localparam int MEDIAN_FIELD_W = 12;

  // Derived widths.
  localparam int DEPTH    = CHANNELS * WINDOW;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PTR_W    = $clog2(WINDOW);
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MID      = WINDOW / 2;

  typedef logic [SAMPLE_BITS-1:0]    sample_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [PTR_W-1:0]          ptr_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [CH_IDX_W-1:0]       ch_idx_t;
  typedef logic [CHAN_FIELD_W-1:0]   chan_t;
  typedef logic [MEDIAN_FIELD_W-1:0] med_t;

  // One classified job handed from the front to the back.
  typedef struct packed {
    chan_t   channel;
    logic    in_range;
    addr_t   base;
    addr_t   wr_addr;
    sample_t sample;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WRITE,
    BK_READ,
    BK_LAST,
    BK_DONE
  } bk_state_t;

endpackage

FILE: src/msm_in_if.sv
interface msm_in_if;
  logic                                valid;
  logic                                ready;
  logic [msm_pkg::CHAN_FIELD_W-1:0]    channel;
  logic [msm_pkg::SAMPLE_FIELD_W-1:0]  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

FILE: src/msm_out_if.sv
interface msm_out_if;
  logic                                valid;
  logic                                ready;
  logic [msm_pkg::CHAN_FIELD_W-1:0]    channel_out;
  logic [msm_pkg::MEDIAN_FIELD_W-1:0]  median;

  modport source (output valid, output channel_out, output median, input ready);
  modport sink   (input valid, input channel_out, input median, output ready);
endinterface

FILE: src/msm_ram.sv
module msm_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                      rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/msm_front.sv
module msm_front (
  input  logic           clk,
  input  logic           rst_n,
  msm_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           q_push,
  output msm_pkg::job_t  q_job
);

  msm_pkg::ptr_t    ptr_r [msm_pkg::CHANNELS];
  msm_pkg::ptr_t    ptr_nxt;
  msm_pkg::ch_idx_t ch_idx;
  logic             in_range;
  logic             accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept;

  // Classify the beat and work out where its sample lands in the store.
  always_comb begin
    in_range = int'(in_ch.channel) < msm_pkg::CHANNELS;
    ch_idx   = msm_pkg::ch_idx_t'(in_ch.channel);
    ptr_nxt  = (ptr_r[ch_idx] == msm_pkg::ptr_t'(msm_pkg::WINDOW - 1)) ?
               '0 : ptr_r[ch_idx] + msm_pkg::ptr_t'(1);

    q_job.channel  = in_ch.channel;
    q_job.in_range = in_range;
    q_job.base     = msm_pkg::addr_t'(int'(in_ch.channel) * msm_pkg::WINDOW);
    q_job.wr_addr  = q_job.base + msm_pkg::addr_t'(ptr_nxt);
    q_job.sample   = msm_pkg::sample_t'(in_ch.sample);
  end

  // Per-channel write pointers advance before the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < msm_pkg::CHANNELS; c++) begin
        ptr_r[c] <= '0;
      end
    end else if (accept && in_range) begin
      ptr_r[ch_idx] <= ptr_nxt;
    end
  end

endmodule

FILE: src/msm_queue.sv
module msm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  msm_pkg::job_t  push_job,
  input  logic           pop,
  output msm_pkg::job_t  head_job,
  output logic           full,
  output logic           empty
);

  msm_pkg::job_t slot_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign head_job = slot_r[rd_ptr_r];

  // Payload slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

FILE: src/msm_back.sv
module msm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  msm_pkg::job_t  q_head,
  output logic           q_pop,
  msm_out_if.source      out_ch
);

  msm_pkg::bk_state_t state_r, state_nxt;
  msm_pkg::job_t      job_r;
  msm_pkg::ptr_t      rd_cnt_r;
  msm_pkg::cnt_t      cnt_r;
  logic               pend_r;
  logic               ent_vld_r;
  logic               vld_r [msm_pkg::DEPTH];
  msm_pkg::sample_t   s_r   [msm_pkg::WINDOW];
  msm_pkg::sample_t   s_nxt [msm_pkg::WINDOW];
  logic               le    [msm_pkg::WINDOW];
  msm_pkg::sample_t   rdata;
  msm_pkg::sample_t   ins_val;
  msm_pkg::addr_t     raddr;
  logic               we;
  logic               rd_issue;
  logic               load_out;

  logic               out_valid_r;
  msm_pkg::chan_t     out_chan_r;
  msm_pkg::med_t      out_med_r;

  assign raddr = job_r.base + msm_pkg::addr_t'(rd_cnt_r);

  msm_ram #(
    .DATA_W (msm_pkg::SAMPLE_BITS),
    .DEPTH  (msm_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (job_r.wr_addr),
    .wdata (job_r.sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Sequencer: write sample, read window, hand off result; out-of-range: hand-off only.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    rd_issue  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      msm_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = q_head.in_range ? msm_pkg::BK_WRITE : msm_pkg::BK_DONE;
        end
      end
      msm_pkg::BK_WRITE: begin
        we        = 1'b1;
        state_nxt = msm_pkg::BK_READ;
      end
      msm_pkg::BK_READ: begin
        rd_issue = 1'b1;
        if (rd_cnt_r == msm_pkg::ptr_t'(msm_pkg::WINDOW - 1)) begin
          state_nxt = msm_pkg::BK_LAST;
        end
      end
      msm_pkg::BK_LAST: begin
        state_nxt = msm_pkg::BK_DONE;
      end
      msm_pkg::BK_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = msm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = msm_pkg::BK_IDLE;
      end
    endcase
  end

  // Insert the returning entry into the sorted list. Entries never written read as zero.
  always_comb begin
    ins_val = ent_vld_r ? rdata : '0;
    for (int i = 0; i < msm_pkg::WINDOW; i++) begin
      le[i] = (msm_pkg::cnt_t'(i) < cnt_r) && (s_r[i] <= ins_val);
    end
    s_nxt[0] = le[0] ? s_r[0] : ins_val;
    for (int i = 1; i < msm_pkg::WINDOW; i++) begin
      if (le[i]) begin
        s_nxt[i] = s_r[i];
      end else if (le[i-1]) begin
        s_nxt[i] = ins_val;
      end else begin
        s_nxt[i] = s_r[i-1];
      end
    end
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= msm_pkg::BK_IDLE;
      pend_r   <= 1'b0;
      rd_cnt_r <= '0;
      cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= rd_issue;
      if (we) begin
        rd_cnt_r <= '0;
      end else if (rd_issue) begin
        rd_cnt_r <= rd_cnt_r + msm_pkg::ptr_t'(1);
      end
      if (we) begin
        cnt_r <= '0;
      end else if (pend_r) begin
        cnt_r <= cnt_r + msm_pkg::cnt_t'(1);
      end
    end
  end

  // Written flags for the store: a cleared store reads as zeros.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < msm_pkg::DEPTH; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (we) begin
      vld_r[job_r.wr_addr] <= 1'b1;
    end
  end

  // Job payload, read-side flag and the sorted list.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
    end
    ent_vld_r <= vld_r[raddr];
    if (pend_r) begin
      s_r <= s_nxt;
    end
  end

  // Output register holds one finished beat until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_chan_r <= job_r.channel;
      out_med_r  <= job_r.in_range ? msm_pkg::med_t'(s_r[msm_pkg::MID]) : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.channel_out = out_chan_r;
  assign out_ch.median      = out_med_r;

endmodule

FILE: src/multichannel_sliding_median_unit.sv
// Channel   Direction  Fields                    Handshake
// in_ch     input      channel[1:0], sample[11:0]   valid/ready
// out_ch    output     channel_out[1:0], median[11:0] valid/ready
//
// In the back end each beat writes its sample to the store, then reads the channel's window
// one entry a cycle through the store's single read port; out-of-range beats skip both.
// The front end accepts up to two beats ahead into its queue while the back end works.
// Synchronous active-low reset clears pointers, written flags, queue and output register.
// A stalled result waits in the output register while the back end finishes the next beat.
module multichannel_sliding_median_unit (
  input logic       clk,
  input logic       rst_n,
  msm_in_if.sink    in_ch,
  msm_out_if.source out_ch
);

  msm_pkg::job_t push_job;
  msm_pkg::job_t head_job;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  // Front end: accepts beats and classifies them.
  msm_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (full),
    .q_push (push),
    .q_job  (push_job)
  );

  // Two-entry job queue between front and back.
  msm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (full),
    .empty    (empty)
  );

  // Back end: updates the store and ranks the window.
  msm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (empty),
    .q_head  (head_job),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: src/msm_checker.sv
module msm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [msm_pkg::CHAN_FIELD_W-1:0]    out_channel,
  input logic [msm_pkg::MEDIAN_FIELD_W-1:0]  out_median
);

  logic [2:0] pend_r;

  // Beats accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else if ((in_valid && in_ready) && !(out_valid && out_ready)) begin
      pend_r <= pend_r + 3'd1;
    end else if (!(in_valid && in_ready) && (out_valid && out_ready)) begin
      pend_r <= pend_r - 3'd1;
    end
  end

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A result is only offered for a beat that was taken in.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 3'd0))
    else $error("result without an accepted beat");

  // Queue, back end and output register hold at most four beats.
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd4)
    else $error("too many beats in flight");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(out_median))
    else $error("stalled result changed");

endmodule

bind multichannel_sliding_median_unit msm_checker u_msm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_channel (out_ch.channel_out),
  .out_median  (out_ch.median)
);

FILE: tb/testbench.sv
module testbench;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 12;
  localparam int IDLE_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_BLOCKS  = 20;
  localparam int BLOCK_BEATS    = 50;

  typedef logic [msm_pkg::SAMPLE_FIELD_W-1:0] raw_sample_t;

  // One filtered value as it should leave the block.
  typedef struct packed {
    msm_pkg::chan_t channel;
    msm_pkg::med_t  median;
  } median_result_t;

  // Tracks the per-channel windows and the medians still owed by the block.
  class median_scoreboard;
    msm_pkg::sample_t window_rows [msm_pkg::CHANNELS][msm_pkg::WINDOW];
    int               write_slot [msm_pkg::CHANNELS];
    median_result_t   expected_medians[$];
    int               mismatches;

    function new();
      mismatches = 0;
      for (int c = 0; c < msm_pkg::CHANNELS; c++) begin
        write_slot[c] = 0;
        for (int k = 0; k < msm_pkg::WINDOW; k++) begin
          window_rows[c][k] = '0;
        end
      end
    endfunction

    // Ranks one channel's window and returns the entry at the middle position.
    function msm_pkg::sample_t middle_of_window(int c);
      msm_pkg::sample_t ranked [msm_pkg::WINDOW];
      msm_pkg::sample_t v;
      int               j;
      for (int i = 0; i < msm_pkg::WINDOW; i++) begin
        ranked[i] = window_rows[c][i];
      end
      for (int i = 1; i < msm_pkg::WINDOW; i++) begin
        v = ranked[i];
        j = i;
        while (j > 0 && ranked[j-1] > v) begin
          ranked[j] = ranked[j-1];
          j--;
        end
        ranked[j] = v;
      end
      return ranked[msm_pkg::MID];
    endfunction

    // An accepted input beat: update the window and queue the median it causes.
    function void note_sample(msm_pkg::chan_t ch, raw_sample_t smp);
      median_result_t res;
      int             c;
      c = int'(ch);
      res.channel = ch;
      res.median  = '0;
      // Channels the block does not have leave the state alone and give zero.
      if (c < msm_pkg::CHANNELS) begin
        write_slot[c] = (write_slot[c] + 1) % msm_pkg::WINDOW;
        window_rows[c][write_slot[c]] = msm_pkg::sample_t'(smp);
        res.median = msm_pkg::med_t'(middle_of_window(c));
      end
      expected_medians.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // An accepted result beat: compare it with the oldest median owed.
    task check_median(msm_pkg::chan_t ch, msm_pkg::med_t med);
      median_result_t want;
      if (expected_medians.size() == 0) begin
        report_mismatch($sformatf("unexpected result channel %0d median %0d", ch, med));
      end else begin
        want = expected_medians.pop_front();
        if (ch !== want.channel) begin
          report_mismatch($sformatf("channel_out %0d, expected %0d", ch, want.channel));
        end
        if (med !== want.median) begin
          report_mismatch($sformatf("median %0d on channel %0d, expected %0d",
                                    med, want.channel, want.median));
        end
      end
    endtask

    function int pending();
      return expected_medians.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic hold_request = 1'b0;
  int   idle_cycles = 0;

  median_scoreboard sb = new();

  msm_in_if  in_bus();
  msm_out_if out_bus();

  multichannel_sliding_median_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus.sink),
    .out_ch (out_bus.source)
  );

  always #HALF_PERIOD clk = ~clk;

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  // Offers one beat and holds it until the block takes it.
  task automatic send_sample(input msm_pkg::chan_t ch, input raw_sample_t smp,
                             input int gap);
    in_bus.valid   <= 1'b1;
    in_bus.channel <= ch;
    in_bus.sample  <= smp;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Watches both channels at each edge and stops a run that has stalled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        sb.note_sample(in_bus.channel, in_bus.sample);
      end
      if (out_bus.valid && out_bus.ready) begin
        sb.check_median(out_bus.channel_out, out_bus.median);
      end
    end
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("multichannel_sliding_median_unit verification failed");
      $finish;
    end
  end

  // Result side: runs of ready, random stalls, and one long hold-off on request.
  initial begin
    int  run;
    bit  hold_done;
    hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        // Keep results back long enough for the input side to fill and stall.
        out_bus.ready <= 1'b0;
        run = 0;
        while (run < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          run++;
        end
        hold_done = 1'b1;
      end else if ($urandom_range(0, 2) != 0) begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b0;
        repeat (idle_len() + 1) @(posedge clk);
      end
    end
  end

  // Input side: reset, directed beats, random blocks, then drain and verdict.
  initial begin
    msm_pkg::chan_t ch;
    msm_pkg::chan_t focus;
    raw_sample_t    smp;
    int             level;
    int             v;
    bit             steady;

    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.channel <= '0;
    in_bus.sample  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Full-scale and zero on every channel, while the windows still hold zeros.
    for (int c = 0; c < 4; c++) begin
      send_sample(msm_pkg::chan_t'(c), {msm_pkg::SAMPLE_FIELD_W{1'b1}}, idle_len());
      send_sample(msm_pkg::chan_t'(c), '0, idle_len());
    end
    // More than a full window on one channel, so its ring wraps around.
    for (int k = 0; k < msm_pkg::WINDOW + 2; k++) begin
      send_sample(msm_pkg::chan_t'(1), raw_sample_t'(4000 - 300 * k), 0);
    end
    // Alternating bit patterns.
    send_sample(msm_pkg::chan_t'(3), raw_sample_t'(12'hAAA), idle_len());
    send_sample(msm_pkg::chan_t'(3), raw_sample_t'(12'h555), idle_len());

    // Random blocks: some without gaps, each with a favored channel and level.
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      steady = ($urandom_range(0, 3) == 0);
      focus  = msm_pkg::chan_t'($urandom_range(0, 3));
      level  = $urandom_range(0, 4095);
      if (blk == 2) begin
        hold_request <= 1'b1;
      end
      for (int k = 0; k < BLOCK_BEATS; k++) begin
        ch = ($urandom_range(0, 1) != 0) ? focus : msm_pkg::chan_t'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            smp = raw_sample_t'($urandom_range(0, 4095));
          end
          6, 7: begin
            // Values clustered near one level give many ties in the window.
            v = level + int'($urandom_range(0, 16)) - 8;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            smp = raw_sample_t'(v);
          end
          8: begin
            smp = ($urandom_range(0, 1) != 0) ? raw_sample_t'(12'hFFF) : '0;
          end
          default: begin
            smp = raw_sample_t'(1 << $urandom_range(0, msm_pkg::SAMPLE_FIELD_W - 1));
          end
        endcase
        send_sample(ch, smp, steady ? 0 : idle_len());
      end
    end
    in_bus.valid <= 1'b0;

    // Drain: the watchdog bounds this wait.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("multichannel_sliding_median_unit verification clean");
    end else begin
      $display("multichannel_sliding_median_unit verification failed");
    end
    $finish;
  end

endmodule
